@@ src/softmax_vector_top_macros.svh @@
// Assertion macros shared by the softmax vector block.
`ifndef SOFTMAX_VECTOR_TOP_MACROS_SVH
`define SOFTMAX_VECTOR_TOP_MACROS_SVH
`define SMX_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SMX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ src/smx_pkg.sv @@
//------------------------------------------------------------------------------
// smx_pkg
// Types, constants and the exponent fraction table of the softmax block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package smx_pkg;
  typedef struct packed {
    logic signed [15:0] score;
    logic               last;
  } smx_in_t;

  typedef struct packed {
    logic [16:0] probability;
    logic        last_res;
    logic        overflow;
  } smx_out_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_EXP_RD,
    ST_EXP_M,
    ST_EXP,
    ST_DIV_RD,
    ST_DIV,
    ST_OUT
  } smx_state_t;

  localparam logic [8:0]  LOG2E_Q8 = 9'd369;
  localparam logic [23:0] FRAC_STEP = 24'd11644838;

  // Fraction table: 65536 * 2^(k/256), built by the same fixed recurrence.
  function automatic logic [16:0] frac_entry(input logic [7:0] k);
    logic [63:0] a;
    a = 64'h1_0000_0000;
    for (int i = 0; i < 256; i++) begin
      if (i < int'(k)) begin
        a = a + ((a * 64'(FRAC_STEP)) >> 32);
      end
    end
    return 17'((a + 64'd32768) >> 16);
  endfunction

  function automatic logic [255:0][16:0] build_table();
    logic [255:0][16:0] t;
    for (int k = 0; k < 256; k++) begin
      t[k] = frac_entry(8'(k));
    end
    return t;
  endfunction

  localparam logic [255:0][16:0] FRAC_TABLE = build_table();
endpackage

@@ src/smx_exp.sv @@
//------------------------------------------------------------------------------
// smx_exp
// Two-stage exponent unit: scaled difference, then table lookup and shift.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module smx_exp import smx_pkg::*; (
  input  logic               clk,
  input  logic signed [15:0] x,
  input  logic signed [15:0] mx,
  output logic [16:0]        e
);
  logic [16:0] u;
  logic [25:0] m;
  logic [25:0] m_r;
  logic [17:0] s;
  logic [7:0]  f;
  logic [16:0] t;

  assign u = 17'(17'(signed'({mx[15], mx})) - 17'(signed'({x[15], x})));
  assign m = 26'((26'(u) * 26'(LOG2E_Q8) + 26'd255) >> 8);

  always_ff @(posedge clk) begin
    m_r <= m;
  end

  assign s = 18'((m_r + 26'd255) >> 8);
  assign f = 8'(-m_r[7:0]);
  assign t = FRAC_TABLE[f];
  assign e = (s >= 18'd32) ? 17'd0 : 17'(t >> s[4:0]);
endmodule

@@ src/smx_div.sv @@
//------------------------------------------------------------------------------
// smx_div
// Restoring divider, one quotient bit per cycle: (e << 16) / sum.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module smx_div import smx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] dividend,
  input  logic [22:0] divisor,
  output logic        busy,
  output logic [16:0] quotient
);
  logic [32:0] num;
  logic [23:0] rem;
  logic [5:0]  cnt;
  logic [23:0] trial;

  assign trial = {rem[22:0], num[32]} - {1'b0, divisor};
  assign quotient = num[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd33;
      num  <= {dividend, 16'd0};
      rem  <= '0;
    end else if (busy) begin
      if (trial[23]) begin
        rem <= {rem[22:0], num[32]};
        num <= {num[31:0], 1'b0};
      end else begin
        rem <= trial;
        num <= {num[31:0], 1'b1};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

@@ src/softmax_vector_top.sv @@
//------------------------------------------------------------------------------
// softmax_vector_top
// Per-vector softmax of signed Q8.8 scores with Q1.16 probabilities.
//------------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one score word per cycle with a
// last flag. Scores are taken at one per cycle while a vector is collected;
// up to MAX_CHANNELS are stored, extra ones are dropped and flagged.
// The word carrying last starts the computation and the block is not ready
// until the whole vector is delivered. The exponent pass handles each score
// with a store read, a scaling stage, then table lookup and shift. Each
// probability then takes a store read, a pass through the shared bit-serial
// divider and an output handshake.
// The output channel out_valid/out_ready holds a word in its register while
// the receiver stalls; the sequencer waits. Reset returns the block to
// collecting an empty vector; stores need no clearing.
`timescale 1ns / 1ps
`include "softmax_vector_top_macros.svh"
module softmax_vector_top import smx_pkg::*; #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  smx_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output smx_out_t out_data
);
  localparam int AW = $clog2(MAX_CHANNELS);
  localparam int CW = $clog2(MAX_CHANNELS + 1);

  logic signed [15:0] score_store [MAX_CHANNELS];
  logic [16:0]        exp_store [MAX_CHANNELS];
  smx_state_t         state, state_next;
  logic [CW-1:0]      entry_count;
  logic [CW-1:0]      idx;
  logic signed [15:0] running_max;
  logic [22:0]        exp_sum;
  logic               dropped_flag;
  logic signed [15:0] score_rd;
  logic [16:0]        exp_rd;
  logic [16:0]        e;
  logic               div_start;
  logic               div_busy;
  logic [16:0]        quotient;
  logic               div_issued;
  logic               accept;

  assign in_ready = (state == ST_COLLECT);
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept && entry_count < CW'(MAX_CHANNELS)) begin
      score_store[entry_count[AW-1:0]] <= in_data.score;
    end
    score_rd <= score_store[idx[AW-1:0]];
    if (state == ST_EXP) begin
      exp_store[idx[AW-1:0]] <= e;
    end
    exp_rd <= exp_store[idx[AW-1:0]];
  end

  smx_exp u_exp (.clk(clk), .x(score_rd), .mx(running_max), .e(e));

  smx_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(exp_rd),
    .divisor(exp_sum), .busy(div_busy), .quotient(quotient)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: if (accept && in_data.last) state_next = ST_EXP_RD;
      ST_EXP_RD:  state_next = ST_EXP_M;
      ST_EXP_M:   state_next = ST_EXP;
      ST_EXP: begin
        if (idx + CW'(1) >= entry_count) state_next = ST_DIV_RD;
        else state_next = ST_EXP_RD;
      end
      ST_DIV_RD:  state_next = ST_DIV;
      ST_DIV:     if (div_issued && !div_busy) state_next = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          if (idx + CW'(1) >= entry_count) state_next = ST_COLLECT;
          else state_next = ST_DIV_RD;
        end
      end
      default:    state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    div_start = (state == ST_DIV) && !div_issued;
  end

  // The store read lands in ST_EXP_M, the exponent unit's register stage
  // in ST_EXP, where the exponent is stored and summed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_COLLECT;
      entry_count  <= '0;
      running_max  <= 16'sh8000;
      exp_sum      <= '0;
      dropped_flag <= 1'b0;
      idx          <= '0;
      div_issued   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_COLLECT: begin
          if (accept) begin
            if (entry_count < CW'(MAX_CHANNELS)) begin
              entry_count <= entry_count + CW'(1);
              if (in_data.score > running_max) begin
                running_max <= in_data.score;
              end
            end else begin
              dropped_flag <= 1'b1;
            end
          end
          idx     <= '0;
          exp_sum <= '0;
        end
        ST_EXP_RD: ;
        ST_EXP_M: ;
        ST_EXP: begin
          exp_sum <= exp_sum + 23'(e);
          if (idx + CW'(1) >= entry_count) idx <= '0;
          else idx <= idx + CW'(1);
        end
        ST_DIV_RD: div_issued <= 1'b0;
        ST_DIV: begin
          if (!div_issued) div_issued <= 1'b1;
          else if (!div_busy) begin
            out_valid            <= 1'b1;
            out_data.probability <= quotient;
            out_data.last_res    <= (idx + CW'(1) >= entry_count);
            out_data.overflow    <= dropped_flag;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (idx + CW'(1) >= entry_count) begin
              entry_count  <= '0;
              running_max  <= 16'sh8000;
              exp_sum      <= '0;
              dropped_flag <= 1'b0;
              idx          <= '0;
            end else begin
              idx <= idx + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  `SMX_ASSERT_IMPL(a_no_accept_busy, state != ST_COLLECT, !in_ready,
    "input accepted while vector is being processed")
  `SMX_ASSERT_IMPL(a_count_bound, 1'b1, entry_count <= CW'(MAX_CHANNELS),
    "entry count exceeds capacity")
  `SMX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_data), "output word changed while stalled")
  `SMX_ASSERT_IMPL(a_prob_bound, out_valid, out_data.probability <= 17'd65536,
    "probability above one")
endmodule

@@ tb/softmax_vector_checker.sv @@
//------------------------------------------------------------------------------
// softmax_vector_checker
// Watches both channels of the softmax block, predicts each probability word
// from the accepted score words and compares every output word in order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module softmax_vector_checker import smx_pkg::*; #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  smx_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  smx_out_t out_data,
  output int       fail_count,
  output int       pending
);
  logic [16:0]        pow2_frac [256];
  logic signed [15:0] held_scores [$];
  logic signed [15:0] vec_max;
  logic               vec_dropped;
  smx_out_t           expected_probs [$];

  initial begin
    logic [63:0] a;
    a = 64'h1_0000_0000;
    for (int k = 0; k < 256; k++) begin
      pow2_frac[k] = 17'((a + 64'd32768) >> 16);
      a = a + ((a * 64'd11644838) >> 32);
    end
  end

  function automatic logic [16:0] exp_value(input int diff);
    int unsigned u, m, s, f;
    u = (diff < 0) ? -diff : 0;
    m = (u * 369 + 255) / 256;
    s = (m + 255) / 256;
    f = (256 * s - m) & 255;
    if (s >= 32) return 17'd0;
    return pow2_frac[f] >> s;
  endfunction

  task automatic predict_vector();
    logic [16:0] e [$];
    logic [22:0] total;
    logic [63:0] p;
    smx_out_t    w;
    total = 0;
    foreach (held_scores[i]) begin
      e.push_back(exp_value(int'(held_scores[i]) - int'(vec_max)));
      total = total + 23'(e[i]);
    end
    foreach (e[i]) begin
      p = (total != 0) ? ((64'(e[i]) << 16) / 64'(total)) : 64'd0;
      w.probability = p[16:0];
      w.last_res = (i == e.size() - 1);
      w.overflow = vec_dropped;
      expected_probs.push_back(w);
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("Mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  assign pending = expected_probs.size();

  initial begin
    fail_count = 0;
    vec_max = -16'sd32768;
    vec_dropped = 1'b0;
  end

  always @(posedge clk) begin
    smx_out_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (held_scores.size() < MAX_CHANNELS) begin
          held_scores.push_back(in_data.score);
          if (in_data.score > vec_max) vec_max = in_data.score;
        end else begin
          vec_dropped = 1'b1;
        end
        if (in_data.last) begin
          predict_vector();
          held_scores.delete();
          vec_max = -16'sd32768;
          vec_dropped = 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_probs.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          want = expected_probs.pop_front();
          if (out_data.probability !== want.probability)
            report("probability", out_data.probability, want.probability);
          if (out_data.last_res !== want.last_res)
            report("last_res", out_data.last_res, want.last_res);
          if (out_data.overflow !== want.overflow)
            report("overflow", out_data.overflow, want.overflow);
        end
      end
    end
  end
endmodule

@@ tb/tb_softmax_vector_top.sv @@
//------------------------------------------------------------------------------
// tb_softmax_vector_top
// Drives directed and random score vectors into the softmax block with random
// gaps and output stalls; a checker beside the block predicts and compares.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_softmax_vector_top import smx_pkg::*;;
  localparam int WATCHDOG_LIMIT = 20000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  smx_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  smx_out_t out_data;
  int       fail_count;
  int       pending;
  int       idle_cycles = 0;
  logic     hold_off = 1'b0;

  always #10 clk = ~clk;

  softmax_vector_top #(.MAX_CHANNELS(64)) dut (.*);

  softmax_vector_checker #(.MAX_CHANNELS(64)) checker_i (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_score(input logic signed [15:0] s, input logic lst);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{score: s, last: lst};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_vector(input int len);
    logic signed [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_score(16'($urandom), i == len - 1);
      else
        send_score(base + $signed(16'($urandom_range(0, 2047)) - 16'sd1024),
                   i == len - 1);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int sent;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_score(16'sh7fff, 1'b1);
    send_score(-16'sd32768, 1'b0);
    send_score(16'sh7fff, 1'b1);
    send_score(16'sd0, 1'b0);
    send_score(16'sd256, 1'b0);
    send_score(-16'sd256, 1'b0);
    send_score(16'sd0, 1'b1);
    send_score(16'sh5555, 1'b0);
    send_score(-16'sh5556, 1'b1);
    for (int i = 0; i < 66; i++) send_score(16'(i * 997), i == 65);
    send_random_vector(3);
    hold_off <= 1'b1;
    fork
      begin
        send_random_vector(8);
        send_random_vector(5);
      end
      begin
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
    join
    sent = 0;
    while (sent < 80) begin
      int len;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
      send_random_vector(len);
      sent += len;
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ softmax_vector_top.f @@
+incdir+src
src/smx_pkg.sv
src/smx_exp.sv
src/smx_div.sv
src/softmax_vector_top.sv
tb/softmax_vector_checker.sv
tb/tb_softmax_vector_top.sv
